[design/lscs_pkg.sv]
// ----------------------------------------------------------------------------
// lscs_pkg
// Shared types and constants for the line splice and comment strip filter.
// ----------------------------------------------------------------------------
package lscs_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] NEWLINE   = 8'h0A;

   localparam logic [BYTE_W-1:0] CHAR_MASK_RESET    = 8'hFF;
   localparam logic [BYTE_W-1:0] COMMENT_CHAR_RESET = 8'h23;

   // register index, taken from csr_paddr[2]
   localparam logic REG_CHAR_MASK    = 1'b0;
   localparam logic REG_COMMENT_CHAR = 1'b1;

   // command codes
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // results of one transaction, handed from front to back
   typedef struct packed {
      logic [1:0]              cnt;
      logic                    is_end;
      logic [2:0][BYTE_W-1:0]  bytes;
   } bundle_type;

endpackage

[design/lscs_front.sv]
// ----------------------------------------------------------------------------
// lscs_front
// Accepts input transactions, runs the splice and comment state machine and
// writes the up to three resulting bytes of each transaction to the queue.
// ----------------------------------------------------------------------------
module lscs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_command,
   input  logic [lscs_pkg::BYTE_W-1:0] req_raw_byte,
   input  logic [lscs_pkg::BYTE_W-1:0] char_mask,
   input  logic [lscs_pkg::BYTE_W-1:0] comment_char,
   input  logic                       q_full,
   output logic                       push,
   output lscs_pkg::bundle_type       bundle
);

   typedef enum logic [3:0] {
      PH_START  = 4'b0001,
      PH_TEXT   = 4'b0010,
      PH_NLHELD = 4'b0100,
      PH_SKIP   = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type                   phase;
      logic [1:0]                  n;
      logic [lscs_pkg::BYTE_W-1:0] b0;
      logic [lscs_pkg::BYTE_W-1:0] b1;
   } feed_type;

   // second layer: one spliced byte
   function automatic feed_type feed(input phase_type ph,
                                     input logic [lscs_pkg::BYTE_W-1:0] x,
                                     input logic [lscs_pkg::BYTE_W-1:0] cc);
      feed_type r;
      logic     go_on;
      r.phase = ph;
      r.n     = 2'd0;
      r.b0    = '0;
      r.b1    = '0;
      go_on   = 1'b1;
      unique case (ph)
         PH_SKIP: begin
            if (x == lscs_pkg::NEWLINE) r.phase = PH_NLHELD;
            go_on = 1'b0;
         end
         PH_NLHELD: begin
            if (x == cc) begin
               r.phase = PH_SKIP;
               go_on   = 1'b0;
            end else begin
               r.b0 = lscs_pkg::NEWLINE;
               r.n  = 2'd1;
            end
         end
         default: begin
         end
      endcase
      if (go_on) begin
         if (x == lscs_pkg::NEWLINE) begin
            r.phase = PH_NLHELD;
         end else begin
            r.phase = PH_TEXT;
            if (r.n == 2'd0) r.b0 = x;
            else r.b1 = x;
            r.n = r.n + 2'd1;
         end
      end
      return r;
   endfunction

   phase_type                   phase_ff, phase_in;
   logic                        held_ff, held_in;
   logic [lscs_pkg::BYTE_W-1:0] masked;
   logic [2:0][lscs_pkg::BYTE_W-1:0] emit;
   logic [1:0]                  n;
   logic                        end_mark;
   logic                        do_splice;
   logic                        nl_eaten;
   logic                        req_accept;
   feed_type                    f1, f2;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;
   assign masked     = req_raw_byte & char_mask;

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      emit      = '0;
      n         = 2'd0;
      end_mark  = 1'b0;
      do_splice = 1'b0;
      nl_eaten  = 1'b0;
      f1        = feed(phase_ff, lscs_pkg::BACKSLASH, comment_char);
      f2        = f1;
      if (req_command == lscs_pkg::CMD_END) begin
         if (phase_in != PH_START && held_in) begin
            f1       = feed(phase_in, lscs_pkg::BACKSLASH, comment_char);
            phase_in = f1.phase;
            if (f1.n != 2'd0) begin
               emit[n] = f1.b0;
               n       = n + 2'd1;
            end
            if (f1.n == 2'd2) begin
               emit[n] = f1.b1;
               n       = n + 2'd1;
            end
         end
         if (phase_in == PH_NLHELD) begin
            emit[n] = lscs_pkg::NEWLINE;
            n       = n + 2'd1;
         end
         emit[n]  = '0;
         n        = n + 2'd1;
         end_mark = 1'b1;
         phase_in = PH_START;
         held_in  = 1'b0;
      end else begin
         if (phase_in == PH_START) begin
            held_in = 1'b0;
            if (masked == comment_char) begin
               phase_in = PH_SKIP;
            end else begin
               phase_in  = PH_TEXT;
               do_splice = 1'b1;
            end
         end else begin
            do_splice = 1'b1;
         end
         if (do_splice) begin
            if (held_in) begin
               held_in = 1'b0;
               if (masked == lscs_pkg::NEWLINE) begin
                  nl_eaten = 1'b1;
               end else begin
                  f1       = feed(phase_in, lscs_pkg::BACKSLASH, comment_char);
                  phase_in = f1.phase;
                  if (f1.n != 2'd0) begin
                     emit[n] = f1.b0;
                     n       = n + 2'd1;
                  end
                  if (f1.n == 2'd2) begin
                     emit[n] = f1.b1;
                     n       = n + 2'd1;
                  end
               end
            end
            if (!nl_eaten) begin
               if (masked == lscs_pkg::BACKSLASH) begin
                  held_in = 1'b1;
               end else begin
                  f2       = feed(phase_in, masked, comment_char);
                  phase_in = f2.phase;
                  if (f2.n != 2'd0) begin
                     emit[n] = f2.b0;
                     n       = n + 2'd1;
                  end
                  if (f2.n == 2'd2) begin
                     emit[n] = f2.b1;
                     n       = n + 2'd1;
                  end
               end
            end
         end
      end
   end

   assign bundle.cnt    = n;
   assign bundle.is_end = end_mark;
   assign bundle.bytes  = emit;
   assign push          = req_accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         held_ff  <= 1'b0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == lscs_pkg::CMD_END) |=>
         (phase_ff == PH_START && !held_ff))
      else $error("end transaction did not return to start state");

   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_command == lscs_pkg::CMD_END) |->
         (push && bundle.is_end && bundle.cnt != 2'd0))
      else $error("end transaction without end marker bundle");

endmodule

[design/lscs_queue.sv]
// ----------------------------------------------------------------------------
// lscs_queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module lscs_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lscs_pkg::bundle_type push_data,
   input  logic                 pop,
   output lscs_pkg::bundle_type pop_data,
   output logic                 full,
   output logic                 empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   lscs_pkg::bundle_type mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

[design/lscs_back.sv]
// ----------------------------------------------------------------------------
// lscs_back
// Takes bundles from the queue and sends their bytes one per transaction on
// the result channel through an output register.
// ----------------------------------------------------------------------------
module lscs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  lscs_pkg::bundle_type        head,
   input  logic                        empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lscs_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_is_end,
   output logic                        rsp_last
);

   logic [1:0]                  pos_ff;
   logic                        valid_ff;
   logic [lscs_pkg::BYTE_W-1:0] byte_ff;
   logic                        is_end_ff, last_ff;
   logic                        load, at_last;

   assign load    = !empty && (!valid_ff || !rsp_stall);
   assign at_last = (pos_ff == head.cnt - 2'd1);
   assign pop     = load && at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            pos_ff   <= at_last ? 2'd0 : pos_ff + 2'd1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head.bytes[pos_ff];
         is_end_ff <= head.is_end && at_last;
         last_ff   <= at_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_end   = is_end_ff;
   assign rsp_last     = last_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && is_end_ff) |-> (last_ff && byte_ff == '0))
      else $error("end marker not last or not zero");

   a_pos_in_bundle: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (pos_ff < head.cnt))
      else $error("byte position beyond bundle");

endmodule

[design/line_splice_comment_strip_core.sv]
// ----------------------------------------------------------------------------
// line_splice_comment_strip_core
// Text filter that deletes backslash-newline pairs and drops comment lines.
//
// req channel: one transaction per raw byte (command data) or per end of
// input (command end). req_stall is high only while the bundle queue is full.
// rsp channel: zero to three byte transactions per input transaction; last
// marks the final one of each input, is_end marks the end marker.
// A data transaction is classified in the cycle it is accepted; its
// results pass through the bundle queue and the output register before
// they appear on rsp. Input is taken at one transaction per cycle while
// the queue is not full; the result side moves one byte per cycle while
// rsp is not stalled, so the output register sends an input's results
// one at a time and the queue of QUEUE_DEPTH bundles absorbs the difference.
// Stalling rsp holds the output register; input continues until the queue
// fills. Reset empties the queue and output, returns the filter to the
// stream start state and sets char_mask to 0xff and comment_char to '#'.
// csr port: char_mask at address 0, comment_char at address 4.
// ----------------------------------------------------------------------------
module line_splice_comment_strip_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [lscs_pkg::BYTE_W-1:0]     req_raw_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lscs_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                            rsp_is_end,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lscs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lscs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lscs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [lscs_pkg::BYTE_W-1:0] char_mask_ff, comment_char_ff;
   logic                        csr_write;
   logic                        push, pop, q_full, q_empty;
   lscs_pkg::bundle_type        push_data, head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_mask_ff    <= lscs_pkg::CHAR_MASK_RESET;
         comment_char_ff <= lscs_pkg::COMMENT_CHAR_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == lscs_pkg::REG_CHAR_MASK)
            char_mask_ff <= csr_pwdata[lscs_pkg::BYTE_W-1:0];
         else
            comment_char_ff <= csr_pwdata[lscs_pkg::BYTE_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == lscs_pkg::REG_COMMENT_CHAR)
         csr_prdata = {{(lscs_pkg::CSR_DATA_W-lscs_pkg::BYTE_W){1'b0}}, comment_char_ff};
      else
         csr_prdata = {{(lscs_pkg::CSR_DATA_W-lscs_pkg::BYTE_W){1'b0}}, char_mask_ff};
   end

   lscs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_raw_byte (req_raw_byte),
      .char_mask    (char_mask_ff),
      .comment_char (comment_char_ff),
      .q_full       (q_full),
      .push         (push),
      .bundle       (push_data)
   );

   lscs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   lscs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (q_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_end   (rsp_is_end),
      .rsp_last     (rsp_last)
   );

endmodule
